### rtl/eor_pkg.sv
package eor_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int LEN_BITS    = 24;
	localparam int COEF_BITS   = 24;
	localparam int GOAL_BITS   = 24;
	localparam int SCALE_FRAC  = 22;
	localparam int SCALE_BITS  = SCALE_FRAC + 1;

	localparam logic [SCALE_BITS-1:0] SCALE_ONE  = SCALE_BITS'(1) << SCALE_FRAC;
	localparam logic [GOAL_BITS-1:0]  GOAL_RESET = GOAL_BITS'(4613734);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SAMPLE_BITS:0]   span_t;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_SET  = 2'd1,
		REQ_STOP = 2'd2
	} req_type_t;

	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_STEP_MUL  = 5'b00010,
		ST_SCALE     = 5'b00100,
		ST_LEVEL_MUL = 5'b01000,
		ST_LEVEL     = 5'b10000
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic step_mul;
		logic scale_upd;
		logic level_mul;
		logic level_upd;
	} eor_cmd_t;

	typedef struct packed {
		logic ramp_active;
	} eor_status_t;

endpackage

### rtl/eor_if.sv
interface eor_req_if;
	import eor_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [1:0]             req_type;
	sample_t                target_value;
	logic [LEN_BITS-1:0]    ramp_len;
	logic [COEF_BITS-1:0]   attack_step;

	modport source (output valid, req_type, target_value, ramp_len, attack_step,
		input ready);
	modport sink (input valid, req_type, target_value, ramp_len, attack_step,
		output ready);
endinterface

interface eor_res_if;
	import eor_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    ramping;

	modport source (output valid, sample_out, ramping, input ready);
	modport sink (input valid, sample_out, ramping, output ready);
endinterface

### rtl/exponential_overshoot_ramp_unit.sv
// channel  dir  handshake     payload
// req      in   valid/ready   req_type, target_value, ramp_len, attack_step
// res      out  valid/ready   sample_out, ramping (ticks only)
// cfg      in   cfg_we        cfg_wdata = overshoot goal, Q2.22
//
// set, stop and a tick with no ramp running leave the controller idle
// a tick during a ramp runs two multiplies on one controller sequence
// (step_mul, scale, then level_mul, level), each registered before use
// the result is held in an output register; while it waits with res ready
// low no item enters, and the next item may enter in the cycle it is taken
// reset clears all levels and the count; the goal register resets to 1.1
module exponential_overshoot_ramp_unit
	import eor_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [GOAL_BITS-1:0] cfg_wdata,
	eor_req_if.sink              req,
	eor_res_if.source            res
);

	eor_cmd_t    cmd;
	eor_status_t status;

	eor_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	eor_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.req_type     (req.req_type),
		.target_value (req.target_value),
		.ramp_len     (req.ramp_len),
		.attack_step  (req.attack_step),
		.status       (status),
		.sample_out   (res.sample_out),
		.ramping      (res.ramping)
	);

endmodule

### rtl/eor_ctrl.sv
module eor_ctrl
	import eor_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic [1:0]  req_type,
	output logic        req_ready,
	output logic        res_valid,
	input  logic        res_ready,
	input  eor_status_t status,
	output eor_cmd_t    cmd
);

	ctl_state_t state_q;
	logic       out_valid_q;
	logic       acc;
	logic       is_tick;

	assign req_ready = (state_q == ST_IDLE) && (!out_valid_q || res_ready);
	assign acc       = req_valid && req_ready;
	assign is_tick   = (req_type == REQ_TICK);
	assign res_valid = out_valid_q;

	assign cmd.accept    = acc;
	assign cmd.step_mul  = (state_q == ST_STEP_MUL);
	assign cmd.scale_upd = (state_q == ST_SCALE);
	assign cmd.level_mul = (state_q == ST_LEVEL_MUL);
	assign cmd.level_upd = (state_q == ST_LEVEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a tick's result is captured at accept, the ramp math runs after
			if (acc && is_tick) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc && is_tick && status.ramp_active) begin
						state_q <= ST_STEP_MUL;
					end
				end
				ST_STEP_MUL:  state_q <= ST_SCALE;
				ST_SCALE:     state_q <= ST_LEVEL_MUL;
				ST_LEVEL_MUL: state_q <= ST_LEVEL;
				ST_LEVEL:     state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/eor_dpath.sv
module eor_dpath
	import eor_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [GOAL_BITS-1:0]  cfg_wdata,
	input  eor_cmd_t              cmd,
	input  logic [1:0]            req_type,
	input  sample_t               target_value,
	input  logic [LEN_BITS-1:0]   ramp_len,
	input  logic [COEF_BITS-1:0]  attack_step,
	output eor_status_t           status,
	output sample_t               sample_out,
	output logic                  ramping
);

	localparam int P1_BITS  = COEF_BITS + GOAL_BITS;
	localparam int SN_BITS  = GOAL_BITS + 2;
	localparam int P2_BITS  = SAMPLE_BITS + 1 + SCALE_BITS;
	localparam int RND_BITS = P2_BITS - SCALE_FRAC;
	localparam int LVL_BITS = RND_BITS + 2;

	localparam logic signed [LVL_BITS-1:0] SAT_HI =
		LVL_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [LVL_BITS-1:0] SAT_LO = -SAT_HI - LVL_BITS'(1);
	localparam logic [P2_BITS-1:0] RND_HALF = P2_BITS'(1) << (SCALE_FRAC - 1);

	logic [GOAL_BITS-1:0]  goal_cfg_q;
	sample_t               goal_level_q;
	sample_t               cur_level_q;
	sample_t               ramp_start_q;
	span_t                 ramp_span_q;
	logic [SCALE_BITS-1:0] scale_q;
	logic [COEF_BITS-1:0]  coef_q;
	logic [LEN_BITS-1:0]   left_q;
	sample_t               sample_out_q;
	logic                  ramping_q;

	logic [P1_BITS-1:0]    prod1_s1;
	logic                  dneg_s1;
	logic [P2_BITS-1:0]    prod2_s2;
	logic                  sneg_s2;

	logic signed [GOAL_BITS:0] diff;
	logic [GOAL_BITS-1:0]      diff_mag;
	logic [GOAL_BITS-1:0]      step;
	logic signed [SN_BITS-1:0] scale_sum;
	logic [SCALE_BITS-1:0]     scale_nxt;
	logic [SAMPLE_BITS:0]      span_mag;
	logic [P2_BITS-1:0]        rnd_sum;
	logic [RND_BITS-1:0]       rnd;
	logic signed [LVL_BITS-1:0] rnd_s;
	logic signed [LVL_BITS-1:0] lvl_sum;
	sample_t                   lvl_nxt;
	span_t                     set_span;

	assign status.ramp_active = (left_q != '0);
	assign sample_out = sample_out_q;
	assign ramping    = ramping_q;

	// one-pole step toward the overshoot goal
	always_comb begin
		diff = $signed({1'b0, goal_cfg_q})
			- $signed({{(GOAL_BITS + 1 - SCALE_BITS){1'b0}}, scale_q});
		diff_mag = diff[GOAL_BITS] ? GOAL_BITS'(-diff) : diff[GOAL_BITS-1:0];
		step = prod1_s1[P1_BITS-1:COEF_BITS];
		if (dneg_s1) begin
			scale_sum = $signed({{(SN_BITS - SCALE_BITS){1'b0}}, scale_q})
				- $signed({2'b00, step});
		end else begin
			scale_sum = $signed({{(SN_BITS - SCALE_BITS){1'b0}}, scale_q})
				+ $signed({2'b00, step});
		end
		if (scale_sum < 0) begin
			scale_nxt = '0;
		end else if (scale_sum > $signed({{(SN_BITS - SCALE_BITS){1'b0}}, SCALE_ONE})) begin
			scale_nxt = SCALE_ONE;
		end else begin
			scale_nxt = scale_sum[SCALE_BITS-1:0];
		end
	end

	// level = start + span * scale, rounded half away from zero, saturated
	always_comb begin
		span_mag = ramp_span_q[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-ramp_span_q)
			: ramp_span_q;
		rnd_sum  = prod2_s2 + RND_HALF;
		rnd      = rnd_sum[P2_BITS-1:SCALE_FRAC];
		rnd_s    = sneg_s2 ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
		lvl_sum  = $signed({{(LVL_BITS - SAMPLE_BITS){ramp_start_q[SAMPLE_BITS-1]}},
			ramp_start_q}) + rnd_s;
		if (lvl_sum > SAT_HI) begin
			lvl_nxt = SAT_HI[SAMPLE_BITS-1:0];
		end else if (lvl_sum < SAT_LO) begin
			lvl_nxt = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			lvl_nxt = lvl_sum[SAMPLE_BITS-1:0];
		end
		set_span = $signed({target_value[SAMPLE_BITS-1], target_value})
			- $signed({cur_level_q[SAMPLE_BITS-1], cur_level_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.step_mul) begin
			prod1_s1 <= coef_q * diff_mag;
			dneg_s1  <= diff[GOAL_BITS];
		end
		if (cmd.level_mul) begin
			prod2_s2 <= span_mag * scale_q;
			sneg_s2  <= ramp_span_q[SAMPLE_BITS];
		end
		if (cmd.accept && req_type == REQ_TICK) begin
			sample_out_q <= (left_q != '0) ? cur_level_q : goal_level_q;
			ramping_q    <= (left_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_cfg_q   <= GOAL_RESET;
			goal_level_q <= '0;
			cur_level_q  <= '0;
			ramp_start_q <= '0;
			ramp_span_q  <= '0;
			scale_q      <= '0;
			coef_q       <= '0;
			left_q       <= '0;
		end else begin
			if (cfg_we) begin
				goal_cfg_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				case (req_type)
					REQ_SET: begin
						goal_level_q <= target_value;
						scale_q      <= '0;
						if (ramp_len == '0) begin
							cur_level_q <= target_value;
							left_q      <= '0;
						end else begin
							ramp_start_q <= cur_level_q;
							ramp_span_q  <= set_span;
							coef_q       <= attack_step;
							left_q       <= ramp_len;
						end
					end
					REQ_STOP: begin
						goal_level_q <= cur_level_q;
						left_q       <= '0;
						scale_q      <= '0;
					end
					REQ_TICK: begin
						if (left_q == '0) begin
							cur_level_q <= goal_level_q;
						end
					end
					default: ;
				endcase
			end
			if (cmd.scale_upd) begin
				scale_q <= scale_nxt;
			end
			if (cmd.level_upd) begin
				cur_level_q <= lvl_nxt;
				left_q      <= left_q - LEN_BITS'(1);
			end
		end
	end

endmodule

### verif/exponential_overshoot_ramp_unit_tb.sv
`timescale 1ns / 1ps

module exponential_overshoot_ramp_unit_tb;
	import eor_pkg::*;

	localparam int          CLK_HALF_NS    = 6;
	localparam int          RESET_CYCLES   = 4;
	localparam int          MAX_IDLE       = 18;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          SETTLE_CYCLES  = 10;
	localparam longint      TIMEOUT_CYCLES = 500_000;
	localparam logic [1:0]  REQ_UNUSED     = 2'd3;
	localparam sample_t     LEVEL_MAX      = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam sample_t     LEVEL_MIN      = sample_t'(-(1 << (SAMPLE_BITS - 1)));

	typedef struct {
		sample_t level;
		logic    ramping;
	} tick_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [GOAL_BITS-1:0] cfg_wdata;

	eor_req_if req_bus ();
	eor_res_if res_bus ();

	exponential_overshoot_ramp_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.res       (res_bus)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// envelope state mirrored at the block's widths
	logic [GOAL_BITS-1:0]  env_goal_reg;
	sample_t               env_target;
	sample_t               env_level;
	sample_t               env_origin;
	span_t                 env_span;
	logic [SCALE_BITS-1:0] env_scale;
	logic [COEF_BITS-1:0]  env_coef;
	logic [LEN_BITS-1:0]   env_count;

	tick_result_t pending_ticks[$];

	logic        idle_on;
	logic        hold_req;
	int unsigned errors;
	int unsigned n_sent;
	int unsigned n_checked;
	int unsigned n_goals;
	int unsigned kind_count[4];

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns  mismatch %s: got %0d want %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic envelope_step(input logic [1:0] kind, input sample_t level,
		input logic [LEN_BITS-1:0] len, input logic [COEF_BITS-1:0] coef);
		longint d, mag, step, sc, prod, rounded, sum;
		case (kind)
			REQ_SET: begin
				env_target = level;
				env_scale  = '0;
				if (len == '0) begin
					env_level = level;
					env_count = '0;
				end else begin
					env_origin = env_level;
					env_span   = span_t'(longint'(level) - longint'(env_level));
					env_coef   = coef;
					env_count  = len;
				end
			end
			REQ_STOP: begin
				env_target = env_level;
				env_count  = '0;
				env_scale  = '0;
			end
			REQ_TICK: begin
				if (env_count != '0) begin
					pending_ticks.push_back('{env_level, 1'b1});
					// one-pole move of the scale toward the goal, then clamp to 0..1.0
					sc   = longint'(env_scale);
					d    = longint'(env_goal_reg) - sc;
					mag  = (d < 0) ? -d : d;
					step = (longint'(env_coef) * mag) >>> 24;
					sc   = (d < 0) ? sc - step : sc + step;
					if (sc > longint'(SCALE_ONE))
						sc = longint'(SCALE_ONE);
					if (sc < 0)
						sc = 0;
					env_scale = SCALE_BITS'(sc);
					// level = origin + span * scale, rounded half away from zero
					prod    = longint'(env_span) * sc;
					mag     = (prod < 0) ? -prod : prod;
					rounded = (mag + (longint'(1) << (SCALE_FRAC - 1))) >>> SCALE_FRAC;
					if (prod < 0)
						rounded = -rounded;
					sum = longint'(env_origin) + rounded;
					if (sum > longint'(LEVEL_MAX))
						sum = longint'(LEVEL_MAX);
					if (sum < longint'(LEVEL_MIN))
						sum = longint'(LEVEL_MIN);
					env_level = sample_t'(sum);
					env_count = env_count - 1'b1;
				end else begin
					env_level = env_target;
					pending_ticks.push_back('{env_level, 1'b0});
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [1:0] kind, input sample_t level,
		input logic [LEN_BITS-1:0] len, input logic [COEF_BITS-1:0] coef);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid        <= 1'b1;
		req_bus.req_type     <= kind;
		req_bus.target_value <= level;
		req_bus.ramp_len     <= len;
		req_bus.attack_step  <= coef;
		do @(posedge clk); while (!req_bus.ready);
		envelope_step(kind, level, len, coef);
		kind_count[kind]++;
		if (kind != REQ_UNUSED)
			n_sent++;
	endtask

	// unused fields carry noise on ticks
	task automatic send_tick();
		send_item(REQ_TICK, sample_t'($urandom), LEN_BITS'($urandom), COEF_BITS'($urandom));
	endtask

	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_goal(input logic [GOAL_BITS-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		env_goal_reg  = value;
		n_goals++;
	endtask

	function automatic sample_t pick_level();
		case ($urandom_range(0, 7))
			0: return LEVEL_MAX;
			1: return LEVEL_MIN;
			2: return '0;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [COEF_BITS-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return COEF_BITS'($urandom_range(1, 4096));
			default: return COEF_BITS'($urandom);
		endcase
	endfunction

	task automatic test_after_reset();
		send_tick();
		send_item(REQ_UNUSED, LEVEL_MAX, '1, '1);
		send_tick();
	endtask

	task automatic test_jumps();
		send_item(REQ_SET, LEVEL_MAX, '0, '1);
		send_tick();
		send_item(REQ_SET, LEVEL_MIN, '0, '0);
		send_tick();
	endtask

	task automatic test_full_swing();
		send_item(REQ_SET, LEVEL_MAX, LEN_BITS'(6), '1);
		repeat (7) send_tick();
	endtask

	task automatic test_stop_mid_ramp();
		send_item(REQ_SET, LEVEL_MIN, '1, COEF_BITS'(24'h400000));
		repeat (2) send_tick();
		send_item(REQ_STOP, '0, '0, '0);
		send_tick();
	endtask

	// zero coefficient keeps the scale at zero until the count runs out
	task automatic test_frozen_coef();
		send_item(REQ_SET, sample_t'(12345), LEN_BITS'(2), '0);
		repeat (3) send_tick();
	endtask

	task automatic test_output_backpressure();
		idle_on = 1'b0;
		send_item(REQ_SET, pick_level(), LEN_BITS'(40), COEF_BITS'(24'h200000));
		hold_req = 1'b1;
		repeat (30) send_tick();
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned         stop_at;
		int unsigned         n_ticks;
		int unsigned         pick;
		logic [LEN_BITS-1:0] len;
		stop_at = n_sent + n_items;
		while (n_sent < stop_at) begin
			idle_on = ($urandom_range(0, 5) != 0);
			pick    = $urandom_range(0, 99);
			if (pick < 65) begin
				len = ($urandom_range(0, 19) == 0) ? LEN_BITS'($urandom)
					: LEN_BITS'($urandom_range(1, 24));
				send_item(REQ_SET, pick_level(), len, pick_coef());
				n_ticks = $urandom_range(0, ((len > 24) ? 24 : int'(len)) + 3);
			end else if (pick < 77) begin
				send_item(REQ_SET, pick_level(), '0, COEF_BITS'($urandom));
				n_ticks = $urandom_range(0, 3);
			end else if (pick < 87) begin
				send_item(REQ_STOP, sample_t'($urandom), LEN_BITS'($urandom),
					COEF_BITS'($urandom));
				n_ticks = $urandom_range(0, 4);
			end else if (pick < 95) begin
				n_ticks = $urandom_range(1, 8);
			end else begin
				send_item(REQ_UNUSED, sample_t'($urandom), LEN_BITS'($urandom),
					COEF_BITS'($urandom));
				n_ticks = 0;
			end
			repeat (n_ticks) send_tick();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_goal_sweep();
		test_random_traffic(300);
		write_goal(SCALE_ONE);
		test_random_traffic(300);
		write_goal('1);
		test_random_traffic(300);
		write_goal('0);
		test_random_traffic(300);
		write_goal(GOAL_BITS'(2097152));
		test_random_traffic(300);
		write_goal(GOAL_BITS'($urandom_range(4194304, 16777215)));
		test_random_traffic(300);
	endtask

	initial begin
		res_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on) begin
				repeat ($urandom_range(0, MAX_IDLE)) begin
					res_bus.ready <= 1'b0;
					@(posedge clk);
				end
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
		end
	end

	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_ticks.size() == 0) begin
				report_mismatch("sample with nothing pending", res_bus.sample_out, 0);
			end else begin
				want = pending_ticks.pop_front();
				if (res_bus.sample_out !== want.level)
					report_mismatch("sample_out", res_bus.sample_out, want.level);
				if (res_bus.ramping !== want.ramping)
					report_mismatch("ramping", res_bus.ramping, want.ramping);
				n_checked++;
			end
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
		$display("timeout with %0d samples pending", pending_ticks.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = GOAL_RESET;
		req_bus.valid        = 1'b0;
		req_bus.req_type     = REQ_TICK;
		req_bus.target_value = '0;
		req_bus.ramp_len     = '0;
		req_bus.attack_step  = '0;
		idle_on              = 1'b1;
		hold_req             = 1'b0;
		errors               = 0;
		n_sent               = 0;
		n_checked            = 0;
		n_goals              = 1;
		kind_count           = '{default: 0};
		env_goal_reg         = GOAL_RESET;
		env_target           = '0;
		env_level            = '0;
		env_origin           = '0;
		env_span             = '0;
		env_scale            = '0;
		env_coef             = '0;
		env_count            = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_jumps();
		test_full_swing();
		test_stop_mid_ramp();
		test_frozen_coef();
		test_output_backpressure();
		test_goal_sweep();
		wait_idle();

		if (pending_ticks.size() != 0)
			report_mismatch("samples never produced", 0, pending_ticks.size());
		$display("run: %0d ticks, %0d sets, %0d stops, %0d unused codes, %0d goal settings",
			kind_count[REQ_TICK], kind_count[REQ_SET], kind_count[REQ_STOP],
			kind_count[REQ_UNUSED], n_goals);
		$display("run: %0d samples compared, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
rtl/eor_pkg.sv
rtl/eor_if.sv
rtl/eor_ctrl.sv
rtl/eor_dpath.sv
rtl/exponential_overshoot_ramp_unit.sv
verif/exponential_overshoot_ramp_unit_tb.sv
